>>> hw/rtl/vfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_pkg: shared types and constants of the velocity freeze detector
// Field widths, register indexes, register reset values, control commands.
// ----------------------------------------------------------------------------
package vfd_pkg;

	localparam int WINDOW_DEPTH_DEF = 8;

	localparam int VEL_W    = 16;
	localparam int TIME_W   = 32;
	localparam int SPEED_W  = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int RAD_W    = 32;
	localparam int SQ_W     = 31;
	localparam int ROOT_STEPS = 16;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 56;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SECONDS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SECONDS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOVING_THR  = 2'd3;

	localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 16'd256;
	localparam logic [CFG_W-1:0] MIN_SECONDS_RST = 16'd3;
	localparam logic [CFG_W-1:0] MAX_SECONDS_RST = 16'd30;
	localparam logic [CFG_W-1:0] MOVING_THR_RST  = 16'd512;

	// controller to datapath
	typedef struct packed {
		logic cap;   // capture input word
		logic mul;   // square both components
		logic add;   // form radicand, start root
		logic step;  // one root iteration
		logic upd;   // window, freeze analysis, load output
	} vfd_cmd_t;

endpackage

>>> hw/rtl/vfd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_ram: generic single port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> hw/rtl/vfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_ctrl: sequencer of the velocity freeze detector
// Accepts a word, steps the datapath through squaring and the root, then
// loads the output register once it is free.
// ----------------------------------------------------------------------------
module vfd_ctrl import vfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output vfd_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;

	localparam int ITER_W = $clog2(ROOT_STEPS);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_STEPS - 1);

	logic [2:0]        state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.step = 1'b1;
				if (iter_q == ITER_LAST) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (slot_free) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.add) begin
				iter_q <= '0;
			end else if (cmd.step) begin
				iter_q <= iter_q + 1'b1;
			end
			if (cmd.upd) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_root_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add |=> (iter_q == '0 && state_q == ST_ROOT))
		else $error("root iteration count not cleared");

	a_upd_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> (out_valid_q && state_q == ST_IDLE))
		else $error("output word not presented after update");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.cap)
		else $error("input accepted while item in progress");

endmodule

>>> hw/rtl/vfd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfd_dpath: datapath of the velocity freeze detector
// Squares, bit-pair square root, speed window with running total,
// freeze timing and the output register.
// ----------------------------------------------------------------------------
module vfd_dpath import vfd_pkg::*; #(
	parameter int SPEED_WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vfd_cmd_t              cmd,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  in_lost,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int DEPTH  = SPEED_WINDOW_DEPTH;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOT_W  = SPEED_W + PTR_W;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
	localparam logic [TOT_W-1:0]  DEPTH_T   = TOT_W'(DEPTH);

	// configuration
	logic [CFG_W-1:0] limit_q, min_s_q, max_s_q, thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= SPEED_LIMIT_RST;
			min_s_q <= MIN_SECONDS_RST;
			max_s_q <= MAX_SECONDS_RST;
			thr_q   <= MOVING_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED_LIMIT: limit_q <= cfg_data;
				REG_MIN_SECONDS: min_s_q <= cfg_data;
				REG_MAX_SECONDS: max_s_q <= cfg_data;
				REG_MOVING_THR:  thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input capture and squaring
	logic [VEL_W-1:0]  vx_q, vy_q;
	logic [TIME_W-1:0] now_q;
	logic              lost_q;
	logic [VEL_W:0]    ax, ay;
	logic [2*VEL_W+1:0] px, py;
	logic [SQ_W-1:0]   sqx_q, sqy_q;

	assign ax = vx_q[VEL_W-1] ? ((VEL_W+1)'(1 << VEL_W) - {1'b0, vx_q}) : {1'b0, vx_q};
	assign ay = vy_q[VEL_W-1] ? ((VEL_W+1)'(1 << VEL_W) - {1'b0, vy_q}) : {1'b0, vy_q};
	assign px = (2*VEL_W+2)'(ax) * (2*VEL_W+2)'(ax);
	assign py = (2*VEL_W+2)'(ay) * (2*VEL_W+2)'(ay);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			vx_q   <= in_data[15:0];
			vy_q   <= in_data[31:16];
			now_q  <= in_data[63:32];
			lost_q <= in_lost;
		end
		if (cmd.mul) begin
			sqx_q <= px[SQ_W-1:0];
			sqy_q <= py[SQ_W-1:0];
		end
	end

	// square root, one bit pair per cycle
	logic [RAD_W-1:0] rad_q, res_q, bit_q, trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			rad_q <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
			res_q <= '0;
			bit_q <= RAD_W'(1) << 30;
		end else if (cmd.step) begin
			if (rad_q >= trial) begin
				rad_q <= rad_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// speed window
	logic [SPEED_W-1:0] speed, old_speed;
	logic [TOT_W-1:0]   total_q, total_d, thr_scaled;
	logic [FILL_W-1:0]  fill_q;
	logic [PTR_W-1:0]   ptr_q;
	logic               full_now, analyse;

	assign speed = res_q[SPEED_W-1:0];

	vfd_ram #(
		.WIDTH (SPEED_W),
		.DEPTH (DEPTH)
	) u_window (
		.clk   (clk),
		.we    (cmd.upd),
		.addr  (ptr_q),
		.wdata (speed),
		.rdata (old_speed)
	);

	assign full_now   = (fill_q == FILL_FULL);
	assign analyse    = full_now || (fill_q == FILL_FULL - 1'b1);
	assign total_d    = (full_now ? (total_q - TOT_W'(old_speed)) : total_q) + TOT_W'(speed);
	assign thr_scaled = TOT_W'(thr_q) * DEPTH_T;

	// freeze analysis
	logic              frozen_q, proper_q, over_q, moving_q;
	logic [TIME_W-1:0] start_q, still_q;
	logic              frozen_d, proper_d, over_d, moving_d;
	logic [TIME_W-1:0] start_d, still_d, diff;
	logic              ev_f, ev_o, ev_u;

	assign diff = now_q - start_q;

	always_comb begin
		frozen_d = frozen_q;
		proper_d = proper_q;
		over_d   = over_q;
		moving_d = moving_q;
		start_d  = start_q;
		still_d  = still_q;
		ev_f     = 1'b0;
		ev_o     = 1'b0;
		ev_u     = 1'b0;
		if (analyse) begin
			if (speed < limit_q) begin
				if (!frozen_q) begin
					frozen_d = 1'b1;
					start_d  = now_q;
					still_d  = '0;
				end else begin
					still_d = diff;
					priority if (diff >= TIME_W'(min_s_q) && !proper_q && !lost_q) begin
						proper_d = 1'b1;
						ev_f     = 1'b1;
					end else if (diff >= TIME_W'(max_s_q) && !over_q && !lost_q) begin
						over_d = 1'b1;
						ev_o   = 1'b1;
					end
				end
			end else begin
				frozen_d = 1'b0;
				still_d  = '0;
				if (proper_q) begin
					proper_d = 1'b0;
					ev_u     = 1'b1;
				end
				over_d = 1'b0;
			end
			moving_d = (total_d >= thr_scaled);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			fill_q   <= '0;
			ptr_q    <= '0;
			frozen_q <= 1'b0;
			proper_q <= 1'b0;
			over_q   <= 1'b0;
			moving_q <= 1'b0;
			start_q  <= '0;
			still_q  <= '0;
			out_data <= '0;
		end else if (cmd.upd) begin
			total_q  <= total_d;
			fill_q   <= full_now ? fill_q : fill_q + 1'b1;
			ptr_q    <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
			frozen_q <= frozen_d;
			proper_q <= proper_d;
			over_q   <= over_d;
			moving_q <= moving_d;
			start_q  <= start_d;
			still_q  <= still_d;
			out_data <= {1'b0, ev_u, ev_o, ev_f, moving_d, over_d, proper_d,
				still_d, frozen_d, speed};
		end
	end

	a_flags_need_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(proper_q || over_q || still_q != '0) |-> frozen_q)
		else $error("freeze flags set while not frozen");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("window fill beyond depth");

	a_events_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> $onehot0(out_data[54:52]))
		else $error("more than one event in one word");

endmodule

>>> hw/rtl/velocity_freeze_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_freeze_detector: speed from velocity, freeze and moving detection
//
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser, one per tracked
// object update. Each gives one output word on m_tvalid/m_tready/m_tdata.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while
// idle; the user must keep to this, the block itself does not enforce it.
// An accepted word passes a squaring step, an add step, the bit-pair square
// root and the update step, which raises m_tvalid. A new word is taken only
// after the previous one has been through update. A finished word waits in
// the output register while the next one is worked; a receiver stall holds
// the update step until the register frees. Reset clears the window fill,
// running total and freeze state and loads the register defaults; the first
// SPEED_WINDOW_DEPTH - 1 words only fill the window and carry no analysis.
// ----------------------------------------------------------------------------
module velocity_freeze_detector import vfd_pkg::*; #(
	parameter int SPEED_WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// vel_x[15:0], vel_y[31:16], now_seconds[63:32]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// object_lost[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// speed[15:0], is_frozen[16], still_seconds[48:17], proper_freeze[49],
	// over_freeze[50], is_moving[51], freeze_event[52],
	// over_freeze_event[53], unfreeze_event[54], zero[55]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	vfd_cmd_t cmd;

	vfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	vfd_dpath #(
		.SPEED_WINDOW_DEPTH (SPEED_WINDOW_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_tdata),
		.in_lost   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata)
	);

endmodule
